@@ design/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(label, clk_sig, rstn_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
		else $error(msg);

// concurrent assertion on the block clock and reset
`define ASSERT_CLK(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

@@ design/scic_pkg.sv @@
package scic_pkg;

	// defaults for the top-level parameters
	localparam int unsigned QUANTUM_LOG2_DEF  = 4;
	localparam int unsigned GROUP_LOG2_DEF    = 2;
	localparam int unsigned REQUEST_WIDTH_DEF = 30;

	// fixed field widths
	localparam int unsigned OPCODE_W      = 2;
	localparam int unsigned CFG_INDEX_W   = 3;
	localparam int unsigned CFG_DATA_W    = 8;
	localparam int unsigned CLASS_INDEX_W = 8;
	localparam int unsigned CLASS_SIZE_W  = 31;
	localparam int unsigned LOG2_W        = 5;
	localparam int unsigned ALIGN_LOG2_W  = 4;
	localparam int unsigned COUNT_W       = 8;

	// byte spans up to 2^31, bit positions 0..32, exponents of the page size check
	localparam int unsigned VAL_W = 32;
	localparam int unsigned POS_W = 6;
	localparam int unsigned EXP_W = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_BYTE_SIZE  = 2'd0,
		OP_PAGE_CEIL  = 2'd1,
		OP_PAGE_FLOOR = 2'd2
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CHUNK_SIZE_LOG2  = 3'd0,
		CFG_PAGE_SHIFT       = 3'd1,
		CFG_ALIGN_ENABLE     = 3'd2,
		CFG_ALIGN_LOG2       = 3'd3,
		CFG_SIZE_CLASS_COUNT = 3'd4,
		CFG_PAGE_CLASS_COUNT = 3'd5
	} cfg_index_t;

	localparam logic [LOG2_W-1:0]       CHUNK_SIZE_LOG2_RST  = 5'd22;
	localparam logic [LOG2_W-1:0]       PAGE_SHIFT_RST       = 5'd13;
	localparam logic                    ALIGN_ENABLE_RST     = 1'b0;
	localparam logic [ALIGN_LOG2_W-1:0] ALIGN_LOG2_RST       = 4'd6;
	localparam logic [COUNT_W-1:0]      SIZE_CLASS_COUNT_RST = 8'd76;
	localparam logic [COUNT_W-1:0]      PAGE_CLASS_COUNT_RST = 8'd40;

	// ceil(log2(v)) given v - 1: zero for v == 1, else msb position of v - 1 plus one
	function automatic logic [POS_W-1:0] ceil_log2_m1(input logic [VAL_W-1:0] vm1);
		logic [POS_W-1:0] r;
		r = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (vm1[i]) begin
				r = POS_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

@@ design/scic_req_if.sv @@
interface scic_req_if #(
	parameter int unsigned REQUEST_WIDTH = scic_pkg::REQUEST_WIDTH_DEF
);
	logic                            valid;
	logic                            ready;
	logic [scic_pkg::OPCODE_W-1:0]   opcode;
	logic [REQUEST_WIDTH-1:0]        request;

	modport source (output valid, opcode, request, input ready);
	modport sink (input valid, opcode, request, output ready);
endinterface

@@ design/scic_rsp_if.sv @@
interface scic_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [scic_pkg::CLASS_INDEX_W-1:0]   class_index;
	logic [scic_pkg::CLASS_SIZE_W-1:0]    class_size;
	logic                                 out_of_range;

	modport source (output valid, class_index, class_size, out_of_range, input ready);
	modport sink (input valid, class_index, class_size, out_of_range, output ready);
endinterface

@@ design/scic_cfg_if.sv @@
interface scic_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [scic_pkg::CFG_INDEX_W-1:0]   index;
	logic [scic_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/size_class_index_compute.sv @@
// channel  dir  payload
// -------  ---  ---------------------------------------------
// req      in   opcode, request (byte size or page count)
// rsp      out  class_index, class_size, out_of_range
// cfg      in   index, data (register write, always ready)
//
// one transaction per cycle sustained while rsp takes its results; a request moves
// through the input register, the index stage and the floor/select stage into the
// result register, which drives rsp.
// the page floor check needs the index, which sets the depth.
// arst_n clears the valid bits and loads the register defaults; payload is not reset.
// a stalled rsp holds each full stage in place and req.ready drops only once
// all three stages are full.
`include "assert_macros.svh"

module size_class_index_compute #(
	parameter int unsigned QUANTUM_LOG2  = scic_pkg::QUANTUM_LOG2_DEF,
	parameter int unsigned GROUP_LOG2    = scic_pkg::GROUP_LOG2_DEF,
	parameter int unsigned REQUEST_WIDTH = scic_pkg::REQUEST_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	scic_req_if.sink   req,
	scic_rsp_if.source rsp,
	scic_cfg_if.sink   cfg
);
	import scic_pkg::*;

	// index before truncation: shift count up to 32 times the group, plus the group slot
	localparam int unsigned IDX_W  = POS_W + GROUP_LOG2;
	localparam int unsigned SUM_W  = VAL_W + GROUP_LOG2 + 1;
	localparam int unsigned SUM1_W = VAL_W + 1;

	// configuration registers
	logic [LOG2_W-1:0]       chunk_log2_q;
	logic [LOG2_W-1:0]       page_shift_q;
	logic                    align_en_q;
	logic [ALIGN_LOG2_W-1:0] align_log2_q;
	logic [COUNT_W-1:0]      size_cnt_q;
	logic [COUNT_W-1:0]      page_cnt_q;

	// pipeline control
	logic valid_s1;
	logic valid_s2;
	logic rsp_valid_q;
	logic out_en;
	logic en_s2;
	logic en_s1;

	// stage one: captured request
	logic [OPCODE_W-1:0]      opcode_s1;
	logic [REQUEST_WIDTH-1:0] request_s1;

	// stage one logic
	logic [VAL_W-1:0]        chunk;
	logic [VAL_W-1:0]        req_ext;
	logic [VAL_W-1:0]        page_lim;
	logic [VAL_W-1:0]        align_mask;
	logic [VAL_W-1:0]        aligned;
	logic [VAL_W-1:0]        page_bytes;
	logic [VAL_W-1:0]        val;
	logic [VAL_W-1:0]        val_m1;
	logic [VAL_W-1:0]        round_mask;
	logic [VAL_W-1:0]        csize_full;
	logic                    is_byte;
	logic [POS_W-1:0]        base;
	logic [POS_W-1:0]        grp_base;
	logic [POS_W-1:0]        x_log;
	logic [POS_W-1:0]        shift_cnt;
	logic [POS_W-1:0]        low_div;
	logic [GROUP_LOG2-1:0]   slot;
	logic [IDX_W-1:0]        idx_full;
	logic                    oor_c;

	// stage two registers
	logic [OPCODE_W-1:0]     opcode_s2;
	logic                    oor_s2;
	logic                    zero_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic [CLASS_SIZE_W-1:0] csize_s2;
	logic [VAL_W-1:0]        psz_s2;

	// stage two logic: size of the page class at idx_s2
	logic [POS_W-1:0]        grp;
	logic [GROUP_LOG2-1:0]   grp_slot;
	logic [POS_W-1:0]        grp_shift;
	logic [EXP_W-1:0]        g_exp;
	logic [EXP_W-1:0]        m_exp;
	logic                    g_big;
	logic                    m_big;
	logic [VAL_W-1:0]        g_val;
	logic [SUM_W-1:0]        m_wide;
	logic [SUM1_W-1:0]       class_sum;
	logic                    size_over;
	logic                    floor_dec;
	logic [IDX_W-1:0]        idx_adj;
	logic [CLASS_INDEX_W-1:0] class_index_d;
	logic [CLASS_SIZE_W-1:0]  class_size_d;
	logic                     out_of_range_d;

	// result register
	logic [CLASS_INDEX_W-1:0] class_index_q;
	logic [CLASS_SIZE_W-1:0]  class_size_q;
	logic                     out_of_range_q;

	// ------------------------------------------------------------------
	// configuration writes, unknown indexes are dropped
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_log2_q <= CHUNK_SIZE_LOG2_RST;
			page_shift_q <= PAGE_SHIFT_RST;
			align_en_q   <= ALIGN_ENABLE_RST;
			align_log2_q <= ALIGN_LOG2_RST;
			size_cnt_q   <= SIZE_CLASS_COUNT_RST;
			page_cnt_q   <= PAGE_CLASS_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CHUNK_SIZE_LOG2:  chunk_log2_q <= cfg.data[LOG2_W-1:0];
				CFG_PAGE_SHIFT:       page_shift_q <= cfg.data[LOG2_W-1:0];
				CFG_ALIGN_ENABLE:     align_en_q   <= cfg.data[0];
				CFG_ALIGN_LOG2:       align_log2_q <= cfg.data[ALIGN_LOG2_W-1:0];
				CFG_SIZE_CLASS_COUNT: size_cnt_q   <= cfg.data[COUNT_W-1:0];
				CFG_PAGE_CLASS_COUNT: page_cnt_q   <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: a stage loads when it is empty or its contents move on
	// ------------------------------------------------------------------
	assign out_en    = !rsp_valid_q || rsp.ready;
	assign en_s2     = !valid_s2 || out_en;
	assign en_s1     = !valid_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= req.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (out_en) begin
				rsp_valid_q <= valid_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			opcode_s1  <= req.opcode;
			request_s1 <= req.request;
		end
	end

	// ------------------------------------------------------------------
	// stage one: alignment, page scaling, oversize test, leading-one detect, class size and class index
	// ------------------------------------------------------------------
	always_comb begin
		chunk      = VAL_W'(1) << chunk_log2_q;
		req_ext    = VAL_W'(request_s1);
		// page_count << page_shift > chunk exactly when page_count > chunk >> page_shift
		page_lim   = chunk >> page_shift_q;
		align_mask = (VAL_W'(1) << align_log2_q) - VAL_W'(1);
		aligned    = align_en_q ? ((req_ext + align_mask) & ~align_mask) : req_ext;
		// only exact while in range, which is the only case that uses it
		page_bytes = req_ext << page_shift_q;
		is_byte    = (opcode_s1 == OP_BYTE_SIZE);
		val        = is_byte ? aligned : page_bytes;
		base       = is_byte ? POS_W'(QUANTUM_LOG2) : POS_W'(page_shift_q);
		val_m1     = val - VAL_W'(1);
		x_log      = ceil_log2_m1(val_m1);
		grp_base   = base + POS_W'(GROUP_LOG2);

		// small sizes all sit in the first groups at the base spacing
		shift_cnt  = (x_log < grp_base) ? '0 : x_log - grp_base;
		low_div    = (x_log < grp_base + POS_W'(1)) ? base
			: x_log - POS_W'(GROUP_LOG2) - POS_W'(1);
		slot       = GROUP_LOG2'(val_m1 >> low_div);
		idx_full   = (IDX_W'(shift_cnt) << GROUP_LOG2) | IDX_W'(slot);

		// class size: round up to the spacing of the group
		round_mask = (VAL_W'(1) << low_div) - VAL_W'(1);
		csize_full = (val + round_mask) & ~round_mask;

		// oversize test uses the raw request, before alignment
		oor_c      = is_byte ? (req_ext > chunk) : (req_ext > page_lim);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			opcode_s2 <= opcode_s1;
			oor_s2    <= oor_c;
			zero_s2   <= (request_s1 == '0);
			idx_s2    <= idx_full;
			csize_s2  <= csize_full[CLASS_SIZE_W-1:0];
			psz_s2    <= page_bytes;
		end
	end

	// ------------------------------------------------------------------
	// stage two: page floor correction and result select
	// ------------------------------------------------------------------
	always_comb begin
		grp       = idx_s2[IDX_W-1:GROUP_LOG2];
		grp_slot  = idx_s2[GROUP_LOG2-1:0];
		grp_shift = (grp == '0) ? POS_W'(1) : grp;

		// group base 2^(ps + G - 1 + grp), zero in the first group
		g_exp = EXP_W'(page_shift_q) + EXP_W'(GROUP_LOG2) - EXP_W'(1) + EXP_W'(grp);
		g_big = (grp != '0) && (g_exp >= EXP_W'(VAL_W));
		g_val = ((grp == '0) || g_big) ? '0 : VAL_W'(1) << g_exp;

		// slot part (slot + 1) << (shift + ps - 1)
		m_exp  = EXP_W'(page_shift_q) + EXP_W'(grp_shift) - EXP_W'(1);
		m_wide = (SUM_W'(grp_slot) + SUM_W'(1)) << m_exp;
		m_big  = (m_exp >= EXP_W'(VAL_W)) || (m_wide[SUM_W-1:VAL_W] != '0);

		// anything at or above 2^32 is beyond any in-range page span
		class_sum = SUM1_W'(g_val) + SUM1_W'(m_wide[VAL_W-1:0]);
		size_over = g_big || m_big || (class_sum > SUM1_W'(psz_s2));

		floor_dec = (opcode_s2 == OP_PAGE_FLOOR) && !oor_s2 && !zero_s2
			&& (idx_s2 != '0) && size_over;
		idx_adj   = floor_dec ? idx_s2 - IDX_W'(1) : idx_s2;

		class_index_d  = '0;
		class_size_d   = '0;
		out_of_range_d = 1'b0;
		case (opcode_s2) inside
			OP_BYTE_SIZE: begin
				if (oor_s2) begin
					class_index_d  = size_cnt_q;
					out_of_range_d = 1'b1;
				end else if (zero_s2) begin
					class_size_d = CLASS_SIZE_W'(1) << QUANTUM_LOG2;
				end else begin
					class_index_d = CLASS_INDEX_W'(idx_s2);
					class_size_d  = csize_s2;
				end
			end
			OP_PAGE_CEIL, OP_PAGE_FLOOR: begin
				if (oor_s2) begin
					class_index_d  = page_cnt_q;
					out_of_range_d = 1'b1;
				end else if (!zero_s2) begin
					class_index_d = CLASS_INDEX_W'(idx_adj);
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			class_index_q  <= class_index_d;
			class_size_q   <= class_size_d;
			out_of_range_q <= out_of_range_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.class_index  = class_index_q;
	assign rsp.class_size   = class_size_q;
	assign rsp.out_of_range = out_of_range_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`ASSERT_CLK(a_accept_fills_s1, (req.valid && req.ready) |=> valid_s1, "accepted item lost")
	`ASSERT_CLK(a_s1_holds_on_stall, (valid_s1 && !en_s2) |=> valid_s1, "stalled s1 dropped")
	`ASSERT_CLK(a_oor_no_size, (rsp_valid_q && out_of_range_q) |-> (class_size_q == '0), "oor size")

endmodule

@@ sim/tb.sv @@
module tb;
	import scic_pkg::*;

	// block parameters, kept at their defaults
	localparam int unsigned QLOG2 = QUANTUM_LOG2_DEF;
	localparam int unsigned GLOG2 = GROUP_LOG2_DEF;
	localparam int unsigned REQ_W = REQUEST_WIDTH_DEF;

	localparam bit [63:0] GROUP_MASK = (64'd1 << GLOG2) - 64'd1;
	localparam bit [63:0] SAT_CAP    = 64'd1 << 62;

	// the fourth opcode has no enum member; the block must answer it with zeros
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	// three register stages between request and result
	localparam int unsigned PIPE_DEPTH      = 3;
	localparam int unsigned PHASES          = 9;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	localparam int unsigned PRESSURE_PHASE  = 3;
	localparam int unsigned LONG_HOLD       = 300;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam int unsigned TIMEOUT         = 800000;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [REQ_W-1:0]    request;
	} size_request_t;

	typedef struct packed {
		logic [CLASS_INDEX_W-1:0] class_index;
		logic [CLASS_SIZE_W-1:0]  class_size;
		logic                     out_of_range;
	} class_result_t;

	logic clk = 1'b0;
	logic arst_n;

	scic_req_if #(.REQUEST_WIDTH(REQ_W)) req_ch ();
	scic_rsp_if rsp_ch ();
	scic_cfg_if cfg_ch ();

	size_class_index_compute u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// requests waiting to be offered, and class results owed by the block
	size_request_t request_q[$];
	class_result_t class_expect_q[$];

	int unsigned mismatch_count = 0;

	// idle controls, set by the stimulus process between phases (hold_rsp by long_rsp_hold)
	bit sender_idle_on;
	bit recv_idle_on;
	bit long_hold_req;
	bit hold_rsp = 1'b0;

	// shadow copy of the configuration registers
	logic [LOG2_W-1:0]       chunk_log2_cfg;
	logic [LOG2_W-1:0]       page_shift_cfg;
	logic                    align_en_cfg;
	logic [ALIGN_LOG2_W-1:0] align_log2_cfg;
	logic [COUNT_W-1:0]      size_count_cfg;
	logic [COUNT_W-1:0]      page_count_cfg;

	// ---------------------------------------------------------------------
	// class arithmetic
	// ---------------------------------------------------------------------

	// smallest r with 2^r >= v, for v >= 1
	function automatic bit [63:0] log2_ceil(input bit [63:0] v);
		bit [63:0] n;
		bit [63:0] r;
		n = v - 64'd1;
		r = 0;
		while (n != 0) begin
			n = n >> 1;
			r = r + 64'd1;
		end
		return r;
	endfunction

	// left shift that clamps at 2^62 instead of wrapping
	function automatic bit [63:0] sat_shift(input bit [63:0] v, input bit [63:0] s);
		if (v == 0)
			return 64'd0;
		if (s >= 62 || v > (SAT_CAP >> s))
			return SAT_CAP;
		return v << s;
	endfunction

	// byte size of page class idx: group base plus the step within the group
	function automatic bit [63:0] page_span(input bit [63:0] idx, input bit [63:0] ps);
		bit [63:0] grp;
		bit [63:0] sub;
		bit [63:0] base;
		bit [63:0] step;
		bit [63:0] sum;
		grp  = idx >> GLOG2;
		sub  = idx & GROUP_MASK;
		base = (grp == 0) ? 64'd0 : sat_shift(64'd1, ps + GLOG2 - 1 + grp);
		step = sat_shift(sub + 64'd1, ((grp == 0) ? 64'd1 : grp) + ps - 64'd1);
		sum  = base + step;
		return (sum > SAT_CAP) ? SAT_CAP : sum;
	endfunction

	// what the block owes for one request under the current shadow registers
	function automatic class_result_t size_class_of(input logic [OPCODE_W-1:0] op,
			input logic [REQ_W-1:0] raw);
		class_result_t res;
		bit [63:0] chunk;
		bit [63:0] ps;
		bit [63:0] s;
		bit [63:0] x;
		bit [63:0] sh;
		bit [63:0] ld;
		bit [63:0] msk;
		bit [63:0] psz;
		bit [63:0] idx;
		res   = '0;
		idx   = 0;
		chunk = 64'd1 << chunk_log2_cfg;
		ps    = 64'(page_shift_cfg);
		if (op == OP_BYTE_SIZE) begin
			if (raw == 0) begin
				// zero bytes maps to the smallest class
				res.class_size = CLASS_SIZE_W'(64'd1 << QLOG2);
			end else if (64'(raw) > chunk) begin
				// oversize is judged on the raw size, before alignment
				idx = 64'(size_count_cfg);
				res.out_of_range = 1'b1;
			end else begin
				s = 64'(raw);
				if (align_en_cfg) begin
					msk = (64'd1 << align_log2_cfg) - 64'd1;
					s = (s + msk) & ~msk;
				end
				x = log2_ceil(s);
				if (x < GLOG2 + QLOG2 + 1) begin
					sh = 0;
					ld = QLOG2;
				end else begin
					sh = x - (GLOG2 + QLOG2);
					ld = x - GLOG2 - 1;
				end
				idx = (sh << GLOG2) + (((s - 64'd1) >> ld) & GROUP_MASK);
				msk = (64'd1 << ld) - 64'd1;
				res.class_size = CLASS_SIZE_W'((s + msk) & ~msk);
			end
		end else if (op == OP_PAGE_CEIL || op == OP_PAGE_FLOOR) begin
			psz = 64'(raw) << ps;
			if (psz > chunk) begin
				idx = 64'(page_count_cfg);
				res.out_of_range = 1'b1;
			end else if (raw != 0) begin
				x   = log2_ceil(psz);
				sh  = (x < GLOG2 + ps) ? 64'd0 : x - GLOG2 - ps;
				ld  = (x < GLOG2 + ps + 1) ? ps : x - GLOG2 - 1;
				idx = (sh << GLOG2) + (((psz - 64'd1) >> ld) & GROUP_MASK);
				// floor steps back one class when the ceiling overshoots, never below zero
				if (op == OP_PAGE_FLOOR && idx != 0 && page_span(idx, ps) > psz)
					idx = idx - 64'd1;
			end
		end
		res.class_index = idx[CLASS_INDEX_W-1:0];
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	// per-transaction wait, zero when idling is off for this side
	function automatic int unsigned draw_gap(input bit idle_on);
		if (!idle_on || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// mostly sizes spread evenly over bit lengths up to just past the chunk,
	// some raw 30-bit noise and some values around powers of two
	function automatic size_request_t random_request();
		size_request_t it;
		int unsigned pick;
		int unsigned nbits;
		int unsigned span;
		bit [63:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			it.opcode = OP_BYTE_SIZE;
		else if (pick < 70)
			it.opcode = OP_PAGE_CEIL;
		else if (pick < 95)
			it.opcode = OP_PAGE_FLOOR;
		else
			it.opcode = OP_UNUSED;
		if (it.opcode == OP_PAGE_CEIL || it.opcode == OP_PAGE_FLOOR)
			span = (chunk_log2_cfg > page_shift_cfg) ? chunk_log2_cfg - page_shift_cfg + 1 : 1;
		else
			span = chunk_log2_cfg + 1;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			v = 64'($urandom());
		end else if (pick == 1) begin
			nbits = $urandom_range(0, REQ_W - 1);
			v = (64'd1 << nbits) + 64'($urandom_range(0, 2)) - 64'd1;
		end else begin
			nbits = $urandom_range(0, span);
			if (nbits == 0)
				v = 0;
			else
				v = (64'd1 << (nbits - 1)) | (64'($urandom()) & ((64'd1 << (nbits - 1)) - 64'd1));
		end
		it.request = v[REQ_W-1:0];
		return it;
	endfunction

	task automatic queue_request(input logic [OPCODE_W-1:0] op, input bit [63:0] r);
		size_request_t it;
		it.opcode  = op;
		it.request = r[REQ_W-1:0];
		request_q.push_back(it);
	endtask

	// one register write transaction
	task automatic write_reg(input cfg_index_t idx, input int unsigned val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic apply_config(input int unsigned chunk_l2, input int unsigned ps,
			input int unsigned ae, input int unsigned al, input int unsigned sc,
			input int unsigned pc);
		write_reg(CFG_CHUNK_SIZE_LOG2, chunk_l2);
		write_reg(CFG_PAGE_SHIFT, ps);
		write_reg(CFG_ALIGN_ENABLE, ae);
		write_reg(CFG_ALIGN_LOG2, al);
		write_reg(CFG_SIZE_CLASS_COUNT, sc);
		write_reg(CFG_PAGE_CLASS_COUNT, pc);
		// let the last shadow update settle before new items are shaped
		repeat (2) @(posedge clk);
	endtask

	// sender pause: nothing queued, nothing offered, nothing owed
	// sampled on the falling edge, after every rising-edge update has landed
	task automatic wait_drained();
		while (request_q.size() != 0 || req_ch.valid || class_expect_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input class_result_t want,
			input class_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s: expected idx %0d size %0d oor %0b, got idx %0d size %0d oor %0b",
				what, want.class_index, want.class_size, want.out_of_range,
				got.class_index, got.class_size, got.out_of_range);
	endtask

	// ---------------------------------------------------------------------
	// config shadow: follows every accepted register write
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_log2_cfg <= CHUNK_SIZE_LOG2_RST;
			page_shift_cfg <= PAGE_SHIFT_RST;
			align_en_cfg   <= ALIGN_ENABLE_RST;
			align_log2_cfg <= ALIGN_LOG2_RST;
			size_count_cfg <= SIZE_CLASS_COUNT_RST;
			page_count_cfg <= PAGE_CLASS_COUNT_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_index_t'(cfg_ch.index))
				CFG_CHUNK_SIZE_LOG2:  chunk_log2_cfg <= cfg_ch.data[LOG2_W-1:0];
				CFG_PAGE_SHIFT:       page_shift_cfg <= cfg_ch.data[LOG2_W-1:0];
				CFG_ALIGN_ENABLE:     align_en_cfg   <= cfg_ch.data[0];
				CFG_ALIGN_LOG2:       align_log2_cfg <= cfg_ch.data[ALIGN_LOG2_W-1:0];
				CFG_SIZE_CLASS_COUNT: size_count_cfg <= cfg_ch.data[COUNT_W-1:0];
				CFG_PAGE_CLASS_COUNT: page_count_cfg <= cfg_ch.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// request driver: offers queued requests, predicts on each transaction
	// ---------------------------------------------------------------------
	int unsigned send_wait;

	always @(posedge clk or negedge arst_n) begin : drive_requests
		size_request_t nxt;
		bit accepted;
		int unsigned gap;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.opcode  <= OP_BYTE_SIZE;
			req_ch.request <= '0;
			send_wait      <= 0;
		end else begin
			accepted = req_ch.valid && req_ch.ready;
			if (accepted)
				class_expect_q.push_back(size_class_of(req_ch.opcode, req_ch.request));
			// a stalled offer stays put with its payload
			if (!(req_ch.valid && !req_ch.ready)) begin
				gap = accepted ? draw_gap(sender_idle_on) : 0;
				if (accepted && gap != 0) begin
					req_ch.valid <= 1'b0;
					send_wait    <= gap - 1;
				end else if (!accepted && send_wait != 0) begin
					req_ch.valid <= 1'b0;
					send_wait    <= send_wait - 1;
				end else if (request_q.size() != 0) begin
					nxt = request_q.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.opcode  <= nxt.opcode;
					req_ch.request <= nxt.request;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// result monitor: random back-pressure and in-order checking
	// ---------------------------------------------------------------------
	int unsigned recv_wait;

	always @(posedge clk or negedge arst_n) begin : check_results
		class_result_t want;
		class_result_t got;
		bit taken;
		int unsigned gap;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			taken = rsp_ch.valid && rsp_ch.ready;
			if (taken) begin
				got.class_index  = rsp_ch.class_index;
				got.class_size   = rsp_ch.class_size;
				got.out_of_range = rsp_ch.out_of_range;
				if (class_expect_q.size() == 0) begin
					report_mismatch("result with no request outstanding", '0, got);
				end else begin
					want = class_expect_q.pop_front();
					if (got.class_index !== want.class_index
							|| got.class_size !== want.class_size
							|| got.out_of_range !== want.out_of_range)
						report_mismatch("mismatch", want, got);
				end
			end
			gap = taken ? draw_gap(recv_idle_on) : 0;
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
			end else if (taken && gap != 0) begin
				rsp_ch.ready <= 1'b0;
				recv_wait    <= gap - 1;
			end else if (!taken && !rsp_ch.ready && recv_wait != 0) begin
				rsp_ch.ready <= 1'b0;
				recv_wait    <= recv_wait - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver stall, counted here, so the pipeline fills and req.ready drops
	initial begin : long_rsp_hold
		while (!long_hold_req)
			@(posedge clk);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// stimulus: directed corners, then config phases of random traffic
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int unsigned ph;
		arst_n         = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_CHUNK_SIZE_LOG2;
		cfg_ch.data    = '0;
		sender_idle_on = 1'b1;
		recv_idle_on   = 1'b1;
		long_hold_req  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: 4 MiB chunk, 8 KiB pages, so 512 pages fit
		// byte sizes: zero, smallest classes, first group edge, chunk edge, oversize
		queue_request(OP_BYTE_SIZE, 0);
		queue_request(OP_BYTE_SIZE, 1);
		queue_request(OP_BYTE_SIZE, 16);
		queue_request(OP_BYTE_SIZE, 17);
		queue_request(OP_BYTE_SIZE, 112);
		queue_request(OP_BYTE_SIZE, 113);
		queue_request(OP_BYTE_SIZE, 128);
		queue_request(OP_BYTE_SIZE, 129);
		queue_request(OP_BYTE_SIZE, (64'd1 << 22) - 1);
		queue_request(OP_BYTE_SIZE, 64'd1 << 22);
		queue_request(OP_BYTE_SIZE, (64'd1 << 22) + 1);
		queue_request(OP_BYTE_SIZE, (64'd1 << REQ_W) - 1);
		// page counts: zero, floor held at class zero, in-group rounding, chunk edge
		queue_request(OP_PAGE_CEIL, 0);
		queue_request(OP_PAGE_FLOOR, 0);
		queue_request(OP_PAGE_CEIL, 1);
		queue_request(OP_PAGE_FLOOR, 1);
		queue_request(OP_PAGE_CEIL, 5);
		queue_request(OP_PAGE_FLOOR, 5);
		queue_request(OP_PAGE_FLOOR, 7);
		queue_request(OP_PAGE_CEIL, 512);
		queue_request(OP_PAGE_FLOOR, 512);
		queue_request(OP_PAGE_CEIL, 513);
		queue_request(OP_PAGE_FLOOR, (64'd1 << REQ_W) - 1);
		// unused opcode answers all zeros
		queue_request(OP_UNUSED, (64'd1 << REQ_W) - 1);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				// smallest chunk, coarsest alignment, count extremes
				1: apply_config(13, 10, 1, 12, 255, 1);
				2: apply_config(28, 16, 0, 0, 1, 255);
				4: apply_config(28, 10, 1, 0, $urandom_range(1, 255), $urandom_range(1, 255));
				// pages larger than the chunk: every nonzero count is oversize
				5: apply_config(13, 16, 0, 12, $urandom_range(1, 255), $urandom_range(1, 255));
				default: apply_config($urandom_range(13, 28), $urandom_range(10, 16),
					$urandom_range(0, 1), $urandom_range(0, 12),
					$urandom_range(1, 255), $urandom_range(1, 255));
			endcase
			// mix of phases with and without idle cycles on each side
			sender_idle_on <= (ph % 3 != 2) && (ph != PRESSURE_PHASE);
			recv_idle_on   <= (ph % 4 != 1);
			if (ph == PRESSURE_PHASE)
				long_hold_req <= 1'b1;
			if (ph == 1) begin
				// alignment rounds a tiny size to 4 KiB and chunk - 1 up to the chunk;
				// just past the chunk is oversize even though alignment is on
				queue_request(OP_BYTE_SIZE, 1);
				queue_request(OP_BYTE_SIZE, (64'd1 << 13) - 1);
				queue_request(OP_BYTE_SIZE, (64'd1 << 13) + 1);
			end
			repeat (ITEMS_PER_PHASE) request_q.push_back(random_request());
			wait_drained();
		end

		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0 && class_expect_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#(TIMEOUT);
		$display("FAIL");
		$finish;
	end

endmodule
